### design/iru_pkg.sv
// shared types, register codes and modular arithmetic helpers for the idea round unit
package iru_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned NumKeys = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROUND_KIND = 3'd0,
    REG_KEY_0      = 3'd1,
    REG_KEY_1      = 3'd2,
    REG_KEY_2      = 3'd3,
    REG_KEY_3      = 3'd4,
    REG_KEY_4      = 3'd5,
    REG_KEY_5      = 3'd6
  } cfg_reg_t;

  localparam logic ROUND_FULL = 1'b0;
  localparam logic ROUND_HALF = 1'b1;

  typedef struct packed {
    logic                     round_kind;
    logic [NumKeys-1:0][WordW-1:0] key;
  } cfg_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } blk_t;

  // raw 16x16 product plus its operands, reduced in the following stage
  typedef struct packed {
    logic [2*WordW-1:0] p;
    word_t              x;
    word_t              y;
  } prod_t;

  typedef struct packed {
    blk_t  blk;
    prod_t m5;
    word_t t1;
  } s5_t;

  function automatic prod_t mul_raw(word_t x, word_t y);
    prod_t r;
    r.p = {{WordW{1'b0}}, x} * {{WordW{1'b0}}, y};
    r.x = x;
    r.y = y;
    return r;
  endfunction

  // reduction modulo 2^16+1, zero operand standing for 2^16
  function automatic word_t mul_reduce(prod_t m);
    word_t lo;
    word_t hi;
    word_t r;
    lo = m.p[WordW-1:0];
    hi = m.p[2*WordW-1:WordW];
    if (m.x == '0) begin
      r = word_t'(1) - m.y;
    end else if (m.y == '0) begin
      r = word_t'(1) - m.x;
    end else begin
      r = lo - hi + word_t'(lo < hi);
    end
    return r;
  endfunction

endpackage

### design/iru_cfg.sv
// configuration register file for round kind and subkeys
module iru_cfg import iru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  word_t              cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_index)
        REG_ROUND_KIND: cfg_nxt.round_kind = cfg_data[0];
        REG_KEY_0:      cfg_nxt.key[0] = cfg_data;
        REG_KEY_1:      cfg_nxt.key[1] = cfg_data;
        REG_KEY_2:      cfg_nxt.key[2] = cfg_data;
        REG_KEY_3:      cfg_nxt.key[3] = cfg_data;
        REG_KEY_4:      cfg_nxt.key[4] = cfg_data;
        REG_KEY_5:      cfg_nxt.key[5] = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && cfg_index == REG_ROUND_KIND) |=> $stable(cfg_r.round_kind))
    else $error("round kind changed without a write to it");

  a_key5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && cfg_index == REG_KEY_5) |=> $stable(cfg_r.key[5]))
    else $error("subkey 5 changed without a write to it");

  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    wr && cfg_index == 3'd7 |=> $stable(cfg_r))
    else $error("write to unused index altered a register");

endmodule

### design/iru_pipe.sv
// five-stage round datapath: key mixing, two multiply-add steps, with per-stage valids
module iru_pipe import iru_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  blk_t  in_blk,
  output logic  p5_valid,
  input  logic  dn_ready,
  output s5_t   p5
);

  logic [5:1] v_r;
  logic [6:1] en;

  prod_t m0_r, m3_r;
  word_t b1_r, c1_r;
  blk_t  blk2_r, blk3_r, blk4_r;
  prod_t m4_r;
  word_t t1_4_r, sum4_r;
  s5_t   s5_r;

  logic  half;
  word_t t1_c;

  assign half = (cfg.round_kind == ROUND_HALF);

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en[6] = dn_ready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: outer multiplies and additions, middle words swapped in half rounds for the output transform
  always_ff @(posedge clk) begin
    if (en[1] && in_valid) begin
      m0_r <= mul_raw(cfg.key[0], in_blk.a);
      m3_r <= mul_raw(cfg.key[3], in_blk.d);
      b1_r <= cfg.key[1] + (half ? in_blk.c : in_blk.b);
      c1_r <= cfg.key[2] + (half ? in_blk.b : in_blk.c);
    end
  end

  // stage 2: reduce
  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      blk2_r.a <= mul_reduce(m0_r);
      blk2_r.b <= b1_r;
      blk2_r.c <= c1_r;
      blk2_r.d <= mul_reduce(m3_r);
    end
  end

  // stage 3: first multiply-add product
  always_ff @(posedge clk) begin
    if (en[3] && v_r[2]) begin
      m4_r   <= mul_raw(cfg.key[4], blk2_r.a ^ blk2_r.c);
      blk3_r <= blk2_r;
    end
  end

  assign t1_c = mul_reduce(m4_r);

  // stage 4: reduce t1 and form the second multiplier operand
  always_ff @(posedge clk) begin
    if (en[4] && v_r[3]) begin
      t1_4_r <= t1_c;
      sum4_r <= t1_c + (blk3_r.b ^ blk3_r.d);
      blk4_r <= blk3_r;
    end
  end

  // stage 5: second multiply-add product
  always_ff @(posedge clk) begin
    if (en[5] && v_r[4]) begin
      s5_r.m5  <= mul_raw(cfg.key[5], sum4_r);
      s5_r.t1  <= t1_4_r;
      s5_r.blk <= blk4_r;
    end
  end

  assign p5_valid = v_r[5];
  assign p5 = s5_r;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && en[1] |=> v_r[1])
    else $error("accepted beat did not enter stage one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && !dn_ready |=> v_r[5] && $stable(s5_r))
    else $error("last stage lost or changed a held beat");

  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ready)
    else $error("input stalled while the pipeline has a bubble");

endmodule

### design/idea_round_unit_top.sv
// top level of the idea round unit: config file, datapath and output stage
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, in_word_0..3         | beat in, stall out
//  out     | out_valid, out_stall, out_word_0..3      | beat out, stall in
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write in, always ready
//
// one beat per cycle sustained while out_stall stays low; six register stages, the last
// being the output register that drives out_valid
// stages: products, reduce, product, reduce and add, product, reduce and output register
// rst_n is synchronous; it clears the valids and the config registers, subkeys read as zero
// a stall holds only the stages that are full up to it, bubbles are squeezed out
module idea_round_unit_top import iru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  word_t              in_word_0,
  input  word_t              in_word_1,
  input  word_t              in_word_2,
  input  word_t              in_word_3,
  output logic               out_valid,
  input  logic               out_stall,
  output word_t              out_word_0,
  output word_t              out_word_1,
  output word_t              out_word_2,
  output word_t              out_word_3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  word_t              cfg_data
);

  cfg_t  cfg;
  blk_t  in_blk;
  logic  in_ready;
  logic  p5_valid;
  logic  dn_ready;
  s5_t   p5;

  logic  out_valid_r;
  blk_t  out_r;
  blk_t  out_nxt;
  word_t t2;
  word_t t3;

  iru_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_blk = '{a: in_word_0, b: in_word_1, c: in_word_2, d: in_word_3};

  iru_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_blk   (in_blk),
    .p5_valid (p5_valid),
    .dn_ready (dn_ready),
    .p5       (p5)
  );

  assign in_stall = !in_ready;
  assign dn_ready = !out_valid_r || !out_stall;

  // final reduce and output mixing; half rounds pass the block through
  always_comb begin
    t2 = mul_reduce(p5.m5);
    t3 = t2 + p5.t1;
    if (cfg.round_kind == ROUND_HALF) begin
      out_nxt = p5.blk;
    end else begin
      out_nxt.a = p5.blk.a ^ t2;
      out_nxt.b = p5.blk.c ^ t2;
      out_nxt.c = p5.blk.b ^ t3;
      out_nxt.d = p5.blk.d ^ t3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dn_ready) begin
      out_valid_r <= p5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_ready && p5_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word_0 = out_r.a;
  assign out_word_1 = out_r.b;
  assign out_word_2 = out_r.c;
  assign out_word_3 = out_r.d;

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    p5_valid && dn_ready |=> out_valid_r)
    else $error("finished beat not moved into the output register");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !p5_valid |=> !out_valid_r)
    else $error("delivered beat repeated");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> dn_ready)
    else $error("empty output stage blocked the pipeline");

endmodule

### dv/idea_round_unit_top_tb.sv
// self-checking testbench for idea_round_unit_top: queued driver, checking monitor, round predictor
module idea_round_unit_top_tb;
  import iru_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldAt = 500;
  localparam int unsigned HoldCycles = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  word_t              in_word_0 = '0;
  word_t              in_word_1 = '0;
  word_t              in_word_2 = '0;
  word_t              in_word_3 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  word_t              out_word_0;
  word_t              out_word_1;
  word_t              out_word_2;
  word_t              out_word_3;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  word_t              cfg_data = '0;

  // predictor copy of the register file
  logic  cur_kind = ROUND_FULL;
  word_t cur_key [NumKeys];

  blk_t pending_blocks [$];
  blk_t expected_blocks [$];

  int   mismatches = 0;
  int   tx_gap = 0;
  int   rx_left = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  blk_t got;
  blk_t want;

  idea_round_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word_0  (in_word_0),
    .in_word_1  (in_word_1),
    .in_word_2  (in_word_2),
    .in_word_3  (in_word_3),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word_0 (out_word_0),
    .out_word_1 (out_word_1),
    .out_word_2 (out_word_2),
    .out_word_3 (out_word_3),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // multiply modulo 2^16+1, zero standing for 2^16
  function automatic word_t mul65537(word_t x, word_t y);
    longint unsigned a;
    longint unsigned b;
    a = 64'(x);
    b = 64'(y);
    if (a == 64'd0) a = 64'd65536;
    if (b == 64'd0) b = 64'd65536;
    return word_t'((a * b) % 64'd65537);
  endfunction

  function automatic blk_t idea_round(blk_t x);
    blk_t  y;
    word_t a, b, c, d, t1, t2, t3;
    if (cur_kind == ROUND_HALF) begin
      y.a = mul65537(cur_key[0], x.a);
      y.b = cur_key[1] + x.c;
      y.c = cur_key[2] + x.b;
      y.d = mul65537(cur_key[3], x.d);
    end else begin
      a = mul65537(cur_key[0], x.a);
      b = cur_key[1] + x.b;
      c = cur_key[2] + x.c;
      d = mul65537(cur_key[3], x.d);
      t1 = mul65537(cur_key[4], a ^ c);
      t2 = mul65537(cur_key[5], word_t'(t1 + (b ^ d)));
      t3 = t2 + t1;
      y.a = a ^ t2;
      y.b = c ^ t2;
      y.c = b ^ t3;
      y.d = d ^ t3;
    end
    return y;
  endfunction

  function automatic void note_reg_write(logic [CfgIdxW-1:0] idx, word_t data);
    case (idx)
      REG_ROUND_KIND: cur_kind = data[0];
      REG_KEY_0:      cur_key[0] = data;
      REG_KEY_1:      cur_key[1] = data;
      REG_KEY_2:      cur_key[2] = data;
      REG_KEY_3:      cur_key[3] = data;
      REG_KEY_4:      cur_key[4] = data;
      REG_KEY_5:      cur_key[5] = data;
      default: ;
    endcase
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      default: return word_t'($urandom);
    endcase
  endfunction

  // leaves cfg_valid high so back-to-back writes follow without a gap
  task automatic write_reg(logic [CfgIdxW-1:0] idx, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    note_reg_write(idx, data);
  endtask

  task automatic load_regs(word_t kind, word_t k0, word_t k1, word_t k2, word_t k3,
                           word_t k4, word_t k5);
    write_reg(REG_ROUND_KIND, kind);
    write_reg(REG_KEY_0, k0);
    write_reg(REG_KEY_1, k1);
    write_reg(REG_KEY_2, k2);
    write_reg(REG_KEY_3, k3);
    write_reg(REG_KEY_4, k4);
    write_reg(REG_KEY_5, k5);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(word_t w0, word_t w1, word_t w2, word_t w3);
    blk_t b;
    b.a = w0;
    b.b = w1;
    b.c = w2;
    b.d = w3;
    pending_blocks.push_back(b);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_blocks.size() != 0 || expected_blocks.size() != 0);
  endtask

  initial begin
    for (int i = 0; i < NumKeys; i++) cur_key[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // subkeys still at their reset value of zero, i.e. 2^16 for the multiplies
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    wait_drained();

    load_regs(word_t'(ROUND_FULL), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    wait_drained();

    load_regs(word_t'(ROUND_FULL), 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001,
              16'h0001);
    send(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    send(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    wait_drained();

    // only bit 0 of the kind register survives
    load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    wait_drained();

    // unused index must leave every register alone
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_ROUND_KIND, 16'hFFFE);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send(16'h0001, 16'hFFFF, 16'h8000, 16'h0000);
    send(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0);
    wait_drained();

    load_regs(word_t'(ROUND_HALF), 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
              16'h0000);
    send(16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
    send(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      tx_calm = ($urandom_range(3) == 0);
      rx_calm = ($urandom_range(3) == 0);
      if ($urandom_range(2) == 0) write_reg(REG_UNUSED, word_t'($urandom));
      load_regs(word_t'($urandom), pick_word(), pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word());
      for (int n = 0; n < PhaseItems; n++) send(pick_word(), pick_word(), pick_word(), pick_word());
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("idea_round_unit_top test passed");
    end else begin
      $display("idea_round_unit_top test failed");
    end
    $finish;
  end

  // driver: holds the beat while stalled, random gap after each accepted beat unless the phase is calm
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(idea_round(pending_blocks.pop_front()));
        tx_gap = tx_calm ? 0 : $urandom_range(9);
      end
      if (in_valid && in_stall) begin
        // payload held
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() != 0) begin
        in_valid  <= 1'b1;
        in_word_0 <= pending_blocks[0].a;
        in_word_1 <= pending_blocks[0].b;
        in_word_2 <= pending_blocks[0].c;
        in_word_3 <= pending_blocks[0].d;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each beat against the oldest prediction, then draws its own stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_word_0, out_word_1, out_word_2, out_word_3};
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          for (int j = 0; j < 4; j++) begin
            if (got[63-16*j -: 16] !== want[63-16*j -: 16]) begin
              $display("%0t: out_word_%0d expected %h actual %h", $time, j,
                       want[63-16*j -: 16], got[63-16*j -: 16]);
              mismatches++;
            end
          end
        end
        results_seen++;
        rx_left = rx_calm ? 0 : $urandom_range(9);
        // long hold-off so the pipeline fills and pushes back on the sender
        if (results_seen == HoldAt) rx_left = HoldCycles;
      end else if (rx_left > 0) begin
        rx_left--;
      end
      out_stall <= (rx_left > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("idea_round_unit_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
